@@ hw/rtl/hnvg_pkg.sv @@
// Package for the heightmap normal/vertex generator.
// Holds configuration register indexes, field widths and fixed-point constants.
// No dependencies.
package hnvg_pkg;

  localparam int unsigned MAX_GRID_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned GRID_W     = 6;
  localparam int unsigned OFF_W      = 15;
  localparam int unsigned DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_OFFSET  = 2'd2;

  localparam logic [GRID_W-1:0] GRID_RESET = 6'd32;

  // Q1.14 unit
  localparam logic [14:0] Q14_ONE = 15'd16384;

endpackage

@@ hw/rtl/heightmap_normal_vertex_gen.sv @@
// Heightmap normal/vertex generator, top level.
// Two row banks in one synchronous memory plus an iterative normalizer.
// Depends on hnvg_pkg.
//
//  channel | direction | signals
//  in      | sink      | in_valid_i, in_ready_o, height_i
//  out     | source    | out_valid_o, out_ready_i, x_pos_o .. last_of_run_o
//  cfg     | sink      | cfg_we_i, cfg_idx_i, cfg_data_i
//
// Each emitted vertex takes four memory reads on the single read port, then 45
// bisection steps (square, low and high 16-bit-slice products, compare) through
// the multiplier path. A sample that emits nothing is only written to the store.
// The final sample of a grid also runs the whole last row.
// Reset clears counters and control; the store needs no clearing.
// A stalled output holds in its register while the next vertex is computed.
module heightmap_normal_vertex_gen #(
  parameter int unsigned MAX_GRID = hnvg_pkg::MAX_GRID_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [hnvg_pkg::DATA_W-1:0] height_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hnvg_pkg::DATA_W-1:0]       x_pos_o,
  output logic signed [hnvg_pkg::DATA_W-1:0] vertex_height_o,
  output logic [hnvg_pkg::DATA_W-1:0]       z_pos_o,
  output logic signed [hnvg_pkg::DATA_W-1:0] normal_x_o,
  output logic signed [hnvg_pkg::DATA_W-1:0] normal_y_o,
  output logic signed [hnvg_pkg::DATA_W-1:0] normal_z_o,
  output logic                              last_of_run_o,
  input  logic                              cfg_we_i,
  input  logic [hnvg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hnvg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hnvg_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_GRID);
  localparam int unsigned NW    = $clog2(MAX_GRID + 1);
  localparam int unsigned DEPTH = 2 * MAX_GRID;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MAG, S_SQ, S_SUM, S_BIT, S_OUT, S_WR
  } state_e;

  state_e state_q;

  logic [GRID_W-1:0] grid_q;
  logic [OFF_W-1:0]  xoff_q, zoff_q;
  logic [CW-1:0]     col_q, row_q, vx_q, vy_q;
  logic signed [DATA_W-1:0] h_q, ctr_q, lf_q, rt_q, up_q;
  logic              has_dn_q, flush_q;
  logic [2:0]        rd_cnt_q;
  logic [14:0]       m_q [3];
  logic [29:0]       sq_q [3];
  logic [2:0]        neg_q;
  logic [31:0]       s_q;
  logic [1:0]        ci_q;
  logic [3:0]        bit_q;
  logic [1:0]        ph_q;
  logic [14:0]       lo_q;
  logic              fail_q;
  logic [29:0]       tsq_q;
  logic [45:0]       plo_q, phi_q;
  logic [14:0]       res_q [3];

  logic              out_valid_q, last_q;
  logic [DATA_W-1:0] x_pos_q, z_pos_q;
  logic signed [DATA_W-1:0] vh_q, nx_q, ny_q, nz_q;

  // row store
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic [AW-1:0]     raddr, waddr;
  logic              mem_we;

  // grid size in use
  logic [NW-1:0] n_w;
  logic [CW-1:0] nm1;
  always_comb begin
    if (grid_q < 6'd2) begin
      n_w = NW'(2);
    end else if ({1'b0, grid_q} > 7'(MAX_GRID)) begin
      n_w = NW'(MAX_GRID);
    end else begin
      n_w = NW'(grid_q);
    end
    nm1 = CW'(n_w - NW'(1));
  end

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    addr_of = r[0] ? AW'(MAX_GRID) + AW'(c) : AW'(c);
  endfunction

  logic x_lo, x_hi, y_lo;
  assign x_lo = (vx_q != '0);
  assign x_hi = (NW'(vx_q) + NW'(1)) < n_w;
  assign y_lo = (vy_q != '0);

  always_comb begin
    case (rd_cnt_q)
      3'd1:    raddr = addr_of(vy_q, x_lo ? vx_q - CW'(1) : vx_q);
      3'd2:    raddr = addr_of(vy_q, x_hi ? vx_q + CW'(1) : vx_q);
      3'd3:    raddr = addr_of(y_lo ? vy_q - CW'(1) : vy_q, vx_q);
      default: raddr = addr_of(vy_q, vx_q);
    endcase
  end

  assign waddr  = addr_of(row_q, col_q);
  assign mem_we = (state_q == S_WR);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= h_q;
    end
    rdata_q <= mem[raddr];
  end

  // normal vector magnitudes
  logic signed [DATA_W-1:0] lf_e, rt_e, up_e, dn_e;
  logic signed [16:0] dh, dv;
  logic [15:0] adh, adv;
  logic [1:0]  sx, sz;
  logic [16:0] m0, m2, mx;
  logic [10:0] m1;
  logic [16:0] m0s, m1s, m2s;
  always_comb begin
    lf_e = x_lo ? lf_q : ctr_q;
    rt_e = x_hi ? rt_q : ctr_q;
    up_e = y_lo ? up_q : ctr_q;
    dn_e = has_dn_q ? h_q : ctr_q;
    dh   = 17'(lf_e) - 17'(rt_e);
    dv   = 17'(up_e) - 17'(dn_e);
    adh  = dh[16] ? 16'(-dh) : dh[15:0];
    adv  = dv[16] ? 16'(-dv) : dv[15:0];
    sx   = 2'(x_lo) + 2'(x_hi);
    sz   = 2'(y_lo) + 2'(has_dn_q);
    m0   = (sz == 2'd2) ? {adh, 1'b0} : {1'b0, adh};
    m2   = (sx == 2'd2) ? {adv, 1'b0} : {1'b0, adv};
    m1   = (sx == 2'd2 && sz == 2'd2) ? 11'd1024 :
           (sx == 2'd2 || sz == 2'd2) ? 11'd512 : 11'd256;
    mx   = (m0 > m2) ? m0 : m2;
    if (17'(m1) > mx) begin
      mx = 17'(m1);
    end
    if (mx < 17'd32768) begin
      m0s = m0;        m1s = 17'(m1);        m2s = m2;
    end else if (mx < 17'd65536) begin
      m0s = m0 >> 1;   m1s = 17'(m1) >> 1;   m2s = m2 >> 1;
    end else begin
      m0s = m0 >> 2;   m1s = 17'(m1) >> 2;   m2s = m2 >> 2;
    end
  end

  // bisection step
  logic [14:0] cand;
  logic [15:0] t2;
  logic [61:0] prod, rhs;
  logic        ok;
  always_comb begin
    cand = lo_q | (15'd1 << bit_q);
    t2   = {cand, 1'b0} - 16'd1;
    prod = {phi_q, 16'b0} + {16'b0, plo_q};
    rhs  = {2'b0, sq_q[ci_q], 30'b0};
    ok   = !fail_q && (prod <= rhs);
  end

  logic can_load;
  assign can_load = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      grid_q      <= GRID_RESET;
      xoff_q      <= '0;
      zoff_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rd_cnt_q    <= '0;
      flush_q     <= 1'b0;
      has_dn_q    <= 1'b0;
      ci_q        <= '0;
      bit_q       <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_SIZE: begin
            grid_q <= cfg_data_i[GRID_W-1:0];
            col_q  <= '0;
            row_q  <= '0;
          end
          CFG_X_OFFSET: xoff_q <= cfg_data_i;
          CFG_Z_OFFSET: zoff_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            h_q      <= height_i;
            rd_cnt_q <= '0;
            flush_q  <= 1'b0;
            has_dn_q <= 1'b1;
            if (NW'(col_q) >= n_w || NW'(row_q) >= n_w || row_q == '0) begin
              if (NW'(col_q) >= n_w || NW'(row_q) >= n_w) begin
                col_q <= '0;
                row_q <= '0;
              end
              state_q <= S_WR;
            end else begin
              vx_q    <= col_q;
              vy_q    <= row_q - CW'(1);
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          rd_cnt_q <= rd_cnt_q + 3'd1;
          case (rd_cnt_q)
            3'd1: ctr_q <= rdata_q;
            3'd2: lf_q  <= rdata_q;
            3'd3: rt_q  <= rdata_q;
            3'd4: begin
              up_q    <= rdata_q;
              state_q <= S_MAG;
            end
            default: ;
          endcase
        end
        S_MAG: begin
          m_q[0]  <= m0s[14:0];
          m_q[1]  <= m1s[14:0];
          m_q[2]  <= m2s[14:0];
          neg_q   <= {(!dv[16] && dv != '0), 1'b1, (!dh[16] && dh != '0)};
          ci_q    <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          sq_q[ci_q] <= m_q[ci_q] * m_q[ci_q];
          if (ci_q == 2'd2) begin
            state_q <= S_SUM;
          end else begin
            ci_q <= ci_q + 2'd1;
          end
        end
        S_SUM: begin
          s_q     <= 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
          ci_q    <= '0;
          bit_q   <= 4'd14;
          ph_q    <= '0;
          lo_q    <= '0;
          state_q <= S_BIT;
        end
        S_BIT: begin
          ph_q <= ph_q + 2'd1;
          case (ph_q)
            2'd0: begin
              fail_q <= cand > Q14_ONE;
              tsq_q  <= t2[14:0] * t2[14:0];
            end
            2'd1: plo_q <= tsq_q * s_q[15:0];
            2'd2: phi_q <= tsq_q * s_q[31:16];
            default: begin
              if (bit_q == '0) begin
                res_q[ci_q] <= ok ? cand : lo_q;
                lo_q        <= '0;
                bit_q       <= 4'd14;
                if (ci_q == 2'd2) begin
                  state_q <= S_OUT;
                end else begin
                  ci_q <= ci_q + 2'd1;
                end
              end else begin
                if (ok) begin
                  lo_q <= cand;
                end
                bit_q <= bit_q - 4'd1;
              end
            end
          endcase
        end
        S_OUT: begin
          if (can_load) begin
            x_pos_q     <= DATA_W'(vx_q) + DATA_W'(xoff_q);
            z_pos_q     <= DATA_W'(vy_q) + DATA_W'(zoff_q);
            vh_q        <= ctr_q;
            nx_q        <= neg_q[0] ? -$signed({1'b0, res_q[0]}) : $signed({1'b0, res_q[0]});
            ny_q        <= neg_q[1] ? -$signed({1'b0, res_q[1]}) : $signed({1'b0, res_q[1]});
            nz_q        <= neg_q[2] ? -$signed({1'b0, res_q[2]}) : $signed({1'b0, res_q[2]});
            last_q      <= flush_q && (vx_q == nm1);
            rd_cnt_q    <= '0;
            if (!flush_q) begin
              state_q <= S_WR;
            end else if (vx_q == nm1) begin
              flush_q <= 1'b0;
              col_q   <= '0;
              row_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              vx_q    <= vx_q + CW'(1);
              state_q <= S_RD;
            end
          end
        end
        S_WR: begin
          rd_cnt_q <= '0;
          if (row_q == nm1 && col_q == nm1) begin
            flush_q  <= 1'b1;
            has_dn_q <= 1'b0;
            vx_q     <= '0;
            vy_q     <= row_q;
            state_q  <= S_RD;
          end else begin
            if (col_q == nm1) begin
              col_q <= '0;
              row_q <= row_q + CW'(1);
            end else begin
              col_q <= col_q + CW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign x_pos_o         = x_pos_q;
  assign vertex_height_o = vh_q;
  assign z_pos_o         = z_pos_q;
  assign normal_x_o      = nx_q;
  assign normal_y_o      = ny_q;
  assign normal_z_o      = nz_q;
  assign last_of_run_o   = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o >= -16'sd16384 && normal_x_o <= 16'sd16384 &&
                     normal_z_o >= -16'sd16384 && normal_z_o <= 16'sd16384))
    else $error("normal component out of Q1.14 range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |->
      (z_pos_o == DATA_W'(nm1) + DATA_W'(zoff_q) && x_pos_o == DATA_W'(nm1) + DATA_W'(xoff_q)))
    else $error("last vertex not at grid corner");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BIT && ph_q == 2'd3 && bit_q == '0 && ci_q == 2'd2) |=> state_q == S_OUT)
    else $error("normalizer did not hand over to output");

endmodule
